FILE: sv/phc_pkg.sv
`default_nettype none
package phc_pkg;

    localparam int DATA_W     = 16;
    localparam int COUNT_W    = 32;
    localparam int IDX_W      = 6;
    localparam int STORE_D    = 64;
    localparam int CFG_ADDR_W = 2;
    localparam int DIV_CNT_W  = $clog2(DATA_W + 1);

    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_SIZE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_SIZE  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BIN_WIDTH = 2'd2;

    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [DATA_W-1:0] MIN_SIZE_RST  = 16'd0;
    localparam logic [DATA_W-1:0] MAX_SIZE_RST  = 16'd1500;
    localparam logic [DATA_W-1:0] BIN_WIDTH_RST = 16'd150;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_DECIDE,
        ST_PKT_RD,
        ST_PKT_WR,
        ST_TICK_RD,
        ST_TICK_ACC
    } state_t;

    typedef struct packed {
        logic capture;
        logic load_result;
        logic rd_en;
        logic wr_en;
        logic clr;
        logic cnt_clr;
        logic cnt_inc;
        logic sum_clr;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic op_tick;
        logic pkt_ok;
        logic nb_zero;
        logic cnt_last;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

FILE: sv/phc_div.sv
`default_nettype none
module phc_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [phc_pkg::DATA_W-1:0] dividend,
    input  wire logic [phc_pkg::DATA_W-1:0] divisor,
    output logic      [phc_pkg::DATA_W-1:0] quotient,
    output logic                            done
);

    localparam int W = phc_pkg::DATA_W;

    logic [W-1:0]                   quo_reg;
    logic [W-1:0]                   rem_reg;
    logic [W-1:0]                   dvs_reg;
    logic [phc_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [W:0]   rem_sh;
    logic [W:0]   trial;
    logic         q_bit;
    logic [W-1:0] rem_next;

    always_comb begin
        rem_sh   = {rem_reg, quo_reg[W-1]};
        trial    = rem_sh - {1'b0, dvs_reg};
        q_bit    = (rem_sh >= {1'b0, dvs_reg});
        rem_next = q_bit ? trial[W-1:0] : rem_sh[W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= phc_pkg::DIV_CNT_W'(W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == phc_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[W-2:0], q_bit};
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule
`default_nettype wire

FILE: sv/phc_ctrl.sv
`default_nettype none
module phc_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  ready,
    input  wire phc_pkg::status_t status,
    output phc_pkg::cmd_t         cmd
);

    phc_pkg::state_t state_reg;
    phc_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= phc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        ready      = 1'b0;
        unique case (state_reg)
            phc_pkg::ST_IDLE: begin
                ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = phc_pkg::ST_DIV;
                end
            end
            phc_pkg::ST_DIV: begin
                if (status.div_done) begin
                    cmd.load_result = 1'b1;
                    state_next      = phc_pkg::ST_DECIDE;
                end
            end
            phc_pkg::ST_DECIDE: begin
                if (status.op_tick) begin
                    if (status.nb_zero) begin
                        cmd.clr    = 1'b1;
                        state_next = phc_pkg::ST_IDLE;
                    end else begin
                        cmd.cnt_clr = 1'b1;
                        cmd.sum_clr = 1'b1;
                        state_next  = phc_pkg::ST_TICK_RD;
                    end
                end else if (status.pkt_ok) begin
                    state_next = phc_pkg::ST_PKT_RD;
                end else begin
                    state_next = phc_pkg::ST_IDLE;
                end
            end
            phc_pkg::ST_PKT_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = phc_pkg::ST_PKT_WR;
            end
            phc_pkg::ST_PKT_WR: begin
                cmd.wr_en  = 1'b1;
                state_next = phc_pkg::ST_IDLE;
            end
            phc_pkg::ST_TICK_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = phc_pkg::ST_TICK_ACC;
            end
            phc_pkg::ST_TICK_ACC: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.cnt_inc  = 1'b1;
                    if (status.cnt_last) begin
                        cmd.clr    = 1'b1;
                        state_next = phc_pkg::ST_IDLE;
                    end else begin
                        state_next = phc_pkg::ST_TICK_RD;
                    end
                end
            end
            default: begin
                state_next = phc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/phc_datapath.sv
`default_nettype none
module phc_datapath #(
    parameter int MAX_BINS = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    input  wire logic [phc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [phc_pkg::DATA_W-1:0]     cfg_data,
    input  wire logic                           s_op,
    input  wire logic [phc_pkg::DATA_W-1:0]     s_pkt_len,
    input  wire logic                           m_ready,
    output logic                                m_valid,
    output logic      [phc_pkg::IDX_W-1:0]      m_bin_index,
    output logic      [phc_pkg::COUNT_W-1:0]    m_cdf_value,
    output logic                                m_last,
    input  wire phc_pkg::cmd_t                  cmd,
    output phc_pkg::status_t                    status
);

    localparam int DW   = phc_pkg::DATA_W;
    localparam int CW   = phc_pkg::COUNT_W;
    localparam int IW   = phc_pkg::IDX_W;
    localparam int NB_W = $clog2(MAX_BINS + 1);
    localparam logic [DW-1:0] MAX_BINS_W = DW'(MAX_BINS);

    logic [DW-1:0] min_size_reg;
    logic [DW-1:0] max_size_reg;
    logic [DW-1:0] bin_width_reg;

    logic          op_reg;
    logic [DW-1:0] len_reg;
    logic [NB_W-1:0] nb_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] bin_cnt_reg;
    logic [CW-1:0] sum_reg;

    logic [CW-1:0] bin_mem [phc_pkg::STORE_D];
    logic [phc_pkg::STORE_D-1:0] bin_vld_reg;
    logic [CW-1:0] rd_data_reg;
    logic          rd_vld_reg;

    logic          m_valid_reg;
    logic [IW-1:0] m_bin_index_reg;
    logic [CW-1:0] m_cdf_value_reg;
    logic          m_last_reg;

    logic [DW-1:0] eff_width;
    logic          range_ok;
    logic [DW-1:0] q_nb;
    logic [DW-1:0] q_idx;
    logic          nb_done;
    logic          idx_done;
    logic [DW-1:0] nb_c;
    logic [DW-1:0] idx_c;
    logic [IW-1:0] rd_addr;
    logic [CW-1:0] bin_val;
    logic [CW-1:0] inc_val;
    logic [CW:0]   sum_wide;
    logic [CW-1:0] sum_next;
    logic          out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_size_reg  <= phc_pkg::MIN_SIZE_RST;
            max_size_reg  <= phc_pkg::MAX_SIZE_RST;
            bin_width_reg <= phc_pkg::BIN_WIDTH_RST;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                phc_pkg::CFG_MIN_SIZE:  min_size_reg  <= cfg_data;
                phc_pkg::CFG_MAX_SIZE:  max_size_reg  <= cfg_data;
                phc_pkg::CFG_BIN_WIDTH: bin_width_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign eff_width = (bin_width_reg == '0) ? DW'(1) : bin_width_reg;
    assign range_ok  = (max_size_reg >= min_size_reg);

    phc_div u_div_nb (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.capture),
        .dividend (max_size_reg - min_size_reg),
        .divisor  (eff_width),
        .quotient (q_nb),
        .done     (nb_done)
    );

    phc_div u_div_idx (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.capture),
        .dividend (s_pkt_len - min_size_reg),
        .divisor  (eff_width),
        .quotient (q_idx),
        .done     (idx_done)
    );

    always_comb begin
        if (!range_ok) begin
            nb_c = '0;
        end else if (q_nb > MAX_BINS_W) begin
            nb_c = MAX_BINS_W;
        end else begin
            nb_c = q_nb;
        end
        idx_c = (q_idx >= nb_c) ? nb_c - DW'(1) : q_idx;
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= s_op;
            len_reg <= s_pkt_len;
        end
        if (cmd.load_result) begin
            nb_reg  <= nb_c[NB_W-1:0];
            idx_reg <= idx_c[IW-1:0];
        end
        if (cmd.cnt_clr) begin
            bin_cnt_reg <= '0;
        end else if (cmd.cnt_inc) begin
            bin_cnt_reg <= bin_cnt_reg + 1'b1;
        end
        if (cmd.sum_clr) begin
            sum_reg <= '0;
        end else if (cmd.out_load) begin
            sum_reg <= sum_next;
        end
    end

    assign rd_addr = (op_reg == phc_pkg::OP_TICK) ? bin_cnt_reg : idx_reg;

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data_reg <= bin_mem[rd_addr];
            rd_vld_reg  <= bin_vld_reg[rd_addr];
        end
        if (cmd.wr_en) begin
            bin_mem[idx_reg] <= inc_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_vld_reg <= '0;
        end else if (cmd.clr) begin
            bin_vld_reg <= '0;
        end else if (cmd.wr_en) begin
            bin_vld_reg[idx_reg] <= 1'b1;
        end
    end

    assign bin_val  = rd_vld_reg ? rd_data_reg : '0;
    assign inc_val  = (&bin_val) ? bin_val : bin_val + 1'b1;
    assign sum_wide = {1'b0, sum_reg} + {1'b0, bin_val};
    assign sum_next = sum_wide[CW] ? '1 : sum_wide[CW-1:0];
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_bin_index_reg <= bin_cnt_reg;
            m_cdf_value_reg <= sum_next;
            m_last_reg      <= status.cnt_last;
        end
    end

    always_comb begin
        status.div_done = nb_done && idx_done;
        status.op_tick  = (op_reg == phc_pkg::OP_TICK);
        status.pkt_ok   = (nb_reg != '0) && (len_reg >= min_size_reg)
                          && (len_reg <= max_size_reg);
        status.nb_zero  = (nb_reg == '0);
        status.cnt_last = ((DW'(bin_cnt_reg) + DW'(1)) == DW'(nb_reg));
        status.out_free = out_free;
    end

    assign m_valid     = m_valid_reg;
    assign m_bin_index = m_bin_index_reg;
    assign m_cdf_value = m_cdf_value_reg;
    assign m_last      = m_last_reg;

endmodule
`default_nettype wire

FILE: sv/packet_size_histogram_cdf.sv
`default_nettype none
// Packet length histogram with cumulative readout. Each input transfer is either a packet
// length event, which adds one to the saturating 32-bit count of the bin that the length
// falls in, or an interval tick, which sends one result per bin carrying the saturating
// running sum of the counts up to that bin, with last on the final bin, and then clears
// the histogram. The block takes one item at a time. Each item first waits on the 16-step
// radix-2 divider that finds the bin count and the bin index; a packet that is counted then
// reads and then writes its bin in the single-port bin memory, and a tick reads the bins in
// force one by one, each read followed by an accumulate step that waits while the receiver
// holds off the previous result, while an ignored packet skips the bin memory. Results
// wait in an output register, so a new item is taken as soon as the last result of a tick
// is registered. The bin counts read as zero from reset on, with no clearing pass.
// Configuration writes are taken in any cycle but should only be issued while idle.
module packet_size_histogram_cdf #(
    parameter int MAX_BINS = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [phc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [phc_pkg::DATA_W-1:0]     cfg_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_op,
    input  wire logic [phc_pkg::DATA_W-1:0]     s_pkt_len,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [phc_pkg::IDX_W-1:0]      m_bin_index,
    output logic      [phc_pkg::COUNT_W-1:0]    m_cdf_value,
    output logic                                m_last
);

    phc_pkg::cmd_t    cmd;
    phc_pkg::status_t status;

    assign cfg_ready = 1'b1;

    phc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .ready   (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    phc_datapath #(
        .MAX_BINS (MAX_BINS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .s_op        (s_op),
        .s_pkt_len   (s_pkt_len),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_bin_index (m_bin_index),
        .m_cdf_value (m_cdf_value),
        .m_last      (m_last),
        .cmd         (cmd),
        .status      (status)
    );

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("A pending result was overwritten.");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("A second item was accepted while one was in progress.");

    a_no_write_on_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_en |-> (!cmd.clr && !cmd.out_load))
        else $error("A bin update coincided with a tick readout or clear.");
`endif

endmodule
`default_nettype wire
